/* rtl/core/tcgb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the text console glyph blitter.
package tcgb_pkg;

   localparam int DIM_WIDTH      = 14;
   localparam int COL_WIDTH      = 14;
   localparam int LINE_WIDTH     = 13;
   localparam int ADDR_WIDTH     = 64;
   localparam int COLOR_WIDTH    = 32;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int GLYPH_COLUMNS  = 8;

   localparam int DEF_GLYPH_ROWS  = 16;
   localparam int DEF_GLYPH_COUNT = 256;
   localparam int DEF_QUEUE_DEPTH = 4;

   localparam logic [DIM_WIDTH-1:0] DIM_MAX          = 14'd8192;
   localparam logic [DIM_WIDTH-1:0] WIDTH_MIN        = 14'd8;
   localparam logic [DIM_WIDTH-1:0] HEIGHT_MIN       = 14'd16;
   localparam logic [DIM_WIDTH-1:0] PITCH_MIN        = 14'd8;
   localparam logic [DIM_WIDTH-1:0] WIDTH_RESET      = 14'd640;
   localparam logic [DIM_WIDTH-1:0] HEIGHT_RESET     = 14'd480;
   localparam logic [DIM_WIDTH-1:0] PITCH_RESET      = 14'd640;

   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] FULL_MASK = 8'hFF;

   // request actions
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_PUT  = 2'd1;
   localparam logic [1:0] ACT_BACK = 2'd2;

   // queued command codes
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_DRAW = 2'd1;
   localparam logic [1:0] OP_FILL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FRAME_BASE    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SCREEN_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SCREEN_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROW_PITCH     = 3'd3;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] frame_base;
      logic [DIM_WIDTH-1:0]  screen_width;
      logic [DIM_WIDTH-1:0]  screen_height;
      logic [DIM_WIDTH-1:0]  row_pitch;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             op;
      logic [COL_WIDTH-1:0]   x;
      logic [LINE_WIDTH-1:0]  line;
      logic [7:0]             char_code;
      logic [3:0]             glyph_row;
      logic [7:0]             font_bits;
      logic [COLOR_WIDTH-1:0] color;
      logic                   blank;
   } blit_cmd_type;

endpackage

/* rtl/core/tcgb_if.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces of the glyph blitter.
interface tcgb_req_if;
   import tcgb_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             action;
   logic [7:0]             char_code;
   logic [3:0]             glyph_row;
   logic [7:0]             font_bits;
   logic [COLOR_WIDTH-1:0] draw_color;

   modport source (output valid, action, char_code, glyph_row, font_bits, draw_color,
                   input ready);
   modport sink (input valid, action, char_code, glyph_row, font_bits, draw_color,
                 output ready);
endinterface

interface tcgb_rsp_if;
   import tcgb_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ADDR_WIDTH-1:0]  pixel_address;
   logic [7:0]             pixel_mask;
   logic [COLOR_WIDTH-1:0] pixel_color;
   logic                   last_row;

   modport source (output valid, pixel_address, pixel_mask, pixel_color, last_row,
                   input ready);
   modport sink (input valid, pixel_address, pixel_mask, pixel_color, last_row,
                 output ready);
endinterface

/* rtl/core/tcgb_front.sv */
`timescale 1ns / 1ps
// Front end: accepts request beats, tracks the cursor and queues blit commands.
module tcgb_front #(
   parameter int GLYPH_ROWS  = tcgb_pkg::DEF_GLYPH_ROWS,
   parameter int GLYPH_COUNT = tcgb_pkg::DEF_GLYPH_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   tcgb_req_if.sink               req_bus,
   input  tcgb_pkg::cfg_type      cfg,
   input  logic                   queue_full,
   output logic                   push,
   output tcgb_pkg::blit_cmd_type push_cmd
);
   import tcgb_pkg::*;

   logic [COL_WIDTH-1:0]  col_ff, col_in;
   logic [LINE_WIDTH-1:0] line_ff, line_in;

   logic                  accept;
   logic [COL_WIDTH:0]    col_sum;
   logic                  wrap;
   logic [LINE_WIDTH+1:0] line_step;
   logic                  step_fits;
   logic [LINE_WIDTH-1:0] wrap_line;
   logic [COL_WIDTH-1:0]  draw_col;
   logic [LINE_WIDTH-1:0] draw_line;
   logic [COL_WIDTH-1:0]  bs_col;
   logic [LINE_WIDTH-1:0] bs_line;
   logic [COL_WIDTH-1:0]  bs_left;
   logic                  glyph_ok;
   logic                  row_ok;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;

   assign col_sum   = (COL_WIDTH+1)'(col_ff) + (COL_WIDTH+1)'(GLYPH_COLUMNS);
   assign wrap      = col_sum >= (COL_WIDTH+1)'(cfg.screen_width);
   assign line_step = (LINE_WIDTH+2)'(line_ff) + (LINE_WIDTH+2)'(GLYPH_ROWS);
   assign step_fits = line_step < (LINE_WIDTH+2)'(cfg.screen_height);

   always_comb begin
      if (step_fits) begin
         wrap_line = LINE_WIDTH'(line_step);
      end else if (cfg.screen_height >= DIM_WIDTH'(GLYPH_ROWS)) begin
         wrap_line = LINE_WIDTH'(cfg.screen_height - DIM_WIDTH'(GLYPH_ROWS));
      end else begin
         wrap_line = '0;
      end
   end

   assign draw_col  = wrap ? '0 : col_ff;
   assign draw_line = wrap ? wrap_line : line_ff;

   always_comb begin
      if (col_ff == '0) begin
         bs_col  = cfg.screen_width;
         bs_line = (line_ff >= LINE_WIDTH'(GLYPH_ROWS)) ?
                   line_ff - LINE_WIDTH'(GLYPH_ROWS) : '0;
      end else begin
         bs_col  = col_ff;
         bs_line = line_ff;
      end
      bs_left = (bs_col >= COL_WIDTH'(GLYPH_COLUMNS)) ?
                bs_col - COL_WIDTH'(GLYPH_COLUMNS) : '0;
   end

   assign glyph_ok = 10'(req_bus.char_code) < 10'(GLYPH_COUNT);
   assign row_ok   = 6'(req_bus.glyph_row) < 6'(GLYPH_ROWS);

   always_comb begin
      col_in             = col_ff;
      line_in            = line_ff;
      push               = 1'b0;
      push_cmd.op        = OP_LOAD;
      push_cmd.x         = draw_col;
      push_cmd.line      = draw_line;
      push_cmd.char_code = req_bus.char_code;
      push_cmd.glyph_row = req_bus.glyph_row;
      push_cmd.font_bits = req_bus.font_bits;
      push_cmd.color     = req_bus.draw_color;
      push_cmd.blank     = !glyph_ok;
      if (accept) begin
         unique case (req_bus.action)
            ACT_LOAD: begin
               push = glyph_ok && row_ok;
            end
            ACT_PUT: begin
               if (req_bus.char_code == CH_CR) begin
                  col_in = '0;
               end else if (req_bus.char_code == CH_LF) begin
                  if (step_fits) begin
                     line_in = LINE_WIDTH'(line_step);
                  end
               end else begin
                  push        = 1'b1;
                  push_cmd.op = OP_DRAW;
                  col_in      = draw_col + COL_WIDTH'(GLYPH_COLUMNS);
                  line_in     = draw_line;
               end
            end
            ACT_BACK: begin
               push          = 1'b1;
               push_cmd.op   = OP_FILL;
               push_cmd.x    = bs_left;
               push_cmd.line = bs_line;
               col_in        = bs_left;
               line_in       = bs_line;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
      end else begin
         col_ff  <= col_in;
         line_ff <= line_in;
      end
   end

endmodule

/* rtl/core/tcgb_queue.sv */
`timescale 1ns / 1ps
// Command queue between the front end and the blit engine.
module tcgb_queue #(
   parameter int DEPTH = tcgb_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tcgb_pkg::blit_cmd_type push_cmd,
   input  logic                   pop,
   output tcgb_pkg::blit_cmd_type head,
   output logic                   full,
   output logic                   empty
);
   import tcgb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   blit_cmd_type          entries_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;

   assign full  = count_ff == CW'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/tcgb_back.sv */
`timescale 1ns / 1ps
// Blit engine: holds the font store and emits one row write beat per glyph row.
module tcgb_back #(
   parameter int GLYPH_ROWS  = tcgb_pkg::DEF_GLYPH_ROWS,
   parameter int GLYPH_COUNT = tcgb_pkg::DEF_GLYPH_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tcgb_pkg::cfg_type      cfg,
   input  logic                   q_empty,
   input  tcgb_pkg::blit_cmd_type q_head,
   output logic                   pop,
   tcgb_rsp_if.source             rsp_bus
);
   import tcgb_pkg::*;

   localparam int RW         = $clog2(GLYPH_ROWS);
   localparam int GW         = $clog2(GLYPH_COUNT);
   localparam int AW         = GW + RW;
   localparam int FONT_DEPTH = GLYPH_COUNT * (1 << RW);
   localparam int PW         = LINE_WIDTH + DIM_WIDTH;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_BASE = 2'd2;
   localparam logic [1:0] ST_ROW  = 2'd3;

   logic [7:0]             font_mem [FONT_DEPTH];
   logic [7:0]             rd_data_ff;

   logic [1:0]             state_ff, state_in;
   logic [RW-1:0]          r_ff, r_in;
   blit_cmd_type           cmd_ff;
   logic [PW-1:0]          prod_ff;
   logic [ADDR_WIDTH-1:0]  addr_ff, addr_in;

   logic                   out_valid_ff, out_valid_in;
   logic [ADDR_WIDTH-1:0]  out_addr_ff;
   logic [7:0]             out_mask_ff;
   logic [COLOR_WIDTH-1:0] out_color_ff;
   logic                   out_last_ff;

   logic                   emit;
   logic                   last;
   logic [RW-1:0]          row_sel;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic                   mem_we;
   logic [ADDR_WIDTH-1:0]  pitch4;
   logic [7:0]             row_mask;

   assign emit    = (state_ff == ST_ROW) && (!out_valid_ff || rsp_bus.ready);
   assign last    = r_ff == RW'(GLYPH_ROWS - 1);
   assign pop     = (state_ff == ST_IDLE) && !q_empty;
   assign mem_we  = pop && (q_head.op == OP_LOAD);
   assign wr_addr = {GW'(q_head.char_code), RW'(q_head.glyph_row)};
   assign row_sel = r_ff + RW'(emit);
   assign rd_addr = {GW'(cmd_ff.char_code), row_sel};
   assign pitch4  = ADDR_WIDTH'({cfg.row_pitch, 2'b00});

   always_comb begin
      if (cmd_ff.op == OP_FILL) begin
         row_mask = FULL_MASK;
      end else if (cmd_ff.blank) begin
         row_mask = '0;
      end else begin
         row_mask = rd_data_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      addr_in  = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            r_in = '0;
            if (pop && q_head.op != OP_LOAD) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_BASE;
         end
         ST_BASE: begin
            addr_in  = cfg.frame_base +
                       ADDR_WIDTH'({(PW+1)'(prod_ff) + (PW+1)'(cmd_ff.x), 2'b00});
            state_in = ST_ROW;
         end
         ST_ROW: begin
            if (emit) begin
               addr_in = addr_ff + pitch4;
               r_in    = r_ff + 1'b1;
               if (last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         font_mem[wr_addr] <= q_head.font_bits;
      end
      rd_data_ff <= font_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         r_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         r_ff         <= r_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= q_head;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PW'(cmd_ff.line) * PW'(cfg.row_pitch);
      end
      addr_ff <= addr_in;
      if (emit) begin
         out_addr_ff  <= addr_ff;
         out_mask_ff  <= row_mask;
         out_color_ff <= cmd_ff.color;
         out_last_ff  <= last;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.pixel_address = out_addr_ff;
   assign rsp_bus.pixel_mask    = out_mask_ff;
   assign rsp_bus.pixel_color   = out_color_ff;
   assign rsp_bus.last_row      = out_last_ff;

`ifndef NO_ASSERTIONS
   a_last_row_ends: assert property (@(posedge clock) disable iff (reset)
      emit && last |=> state_ff == ST_IDLE && rsp_bus.last_row)
      else $error("last row beat did not end the command");
   a_row_stride: assert property (@(posedge clock) disable iff (reset)
      emit && !last |=> addr_ff == $past(addr_ff) + $past(pitch4))
      else $error("row address did not step by the pitch");
   a_fill_mask: assert property (@(posedge clock) disable iff (reset)
      emit && cmd_ff.op == OP_FILL |=> rsp_bus.pixel_mask == FULL_MASK)
      else $error("backspace row beat without full mask");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> cmd_ff.op != OP_LOAD)
      else $error("font load command entered the row sequencer");
`endif

endmodule

/* rtl/core/text_console_glyph_blitter.sv */
`timescale 1ns / 1ps
// Text console glyph blitter top level: control registers, front end, queue, blit engine.
//
//   channel  dir  handshake          payload
//   req_bus  in   valid/ready        action, char_code, glyph_row, font_bits, draw_color
//   rsp_bus  out  valid/ready        pixel_address, pixel_mask, pixel_color, last_row
//   csr_*    in   csr_we, no wait    csr_index, csr_wdata (64 bits)
//
// Drawn character or backspace: the blit engine pops, multiplies and adds the base, then
// emits one row beat a cycle while the response is not stalled.
// Font load: stored on pop. CR, LF and unused actions end in the front end.
// The front end takes a beat each cycle while the command queue has room.
// Reset clears cursor and queue, presets the registers; the font store is not cleared.
// A stalled response holds the row sequencer; requests stall only on a full queue.
module text_console_glyph_blitter #(
   parameter int GLYPH_ROWS  = tcgb_pkg::DEF_GLYPH_ROWS,
   parameter int GLYPH_COUNT = tcgb_pkg::DEF_GLYPH_COUNT,
   parameter int QUEUE_DEPTH = tcgb_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   tcgb_req_if.sink                           req_bus,
   tcgb_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [tcgb_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [tcgb_pkg::ADDR_WIDTH-1:0]    csr_wdata
);
   import tcgb_pkg::*;

   cfg_type                cfg_ff;
   logic                   push;
   blit_cmd_type           push_cmd;
   logic                   pop;
   blit_cmd_type           q_head;
   logic                   q_full;
   logic                   q_empty;

   function automatic logic [DIM_WIDTH-1:0] clamp_dim(
      input logic [ADDR_WIDTH-1:0] value,
      input logic [DIM_WIDTH-1:0]  lo
   );
      logic [DIM_WIDTH-1:0] v;
      v = value[DIM_WIDTH-1:0];
      if (v < lo) begin
         return lo;
      end else if (v > DIM_MAX) begin
         return DIM_MAX;
      end
      return v;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_base    <= '0;
         cfg_ff.screen_width  <= WIDTH_RESET;
         cfg_ff.screen_height <= HEIGHT_RESET;
         cfg_ff.row_pitch     <= PITCH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_BASE:    cfg_ff.frame_base    <= csr_wdata;
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= clamp_dim(csr_wdata, WIDTH_MIN);
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= clamp_dim(csr_wdata, HEIGHT_MIN);
            CSR_ROW_PITCH:     cfg_ff.row_pitch     <= clamp_dim(csr_wdata, PITCH_MIN);
            default: begin
            end
         endcase
      end
   end

   tcgb_front #(
      .GLYPH_ROWS  (GLYPH_ROWS),
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .queue_full (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tcgb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   tcgb_back #(
      .GLYPH_ROWS  (GLYPH_ROWS),
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_head  (q_head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
